// ----- hdl/bit_run_length_histogram_assert.svh -----
// assertion macros shared by the run-length histogram rtl
`ifndef BIT_RUN_LENGTH_HISTOGRAM_ASSERT_SVH
`define BIT_RUN_LENGTH_HISTOGRAM_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BRH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BRH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BRH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/brh_pkg.sv -----
`default_nettype none

package brh_pkg;

    localparam int BRH_BINS        = 64;
    localparam int BRH_COUNT_WIDTH = 32;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // histogram operation carried with an item into the memory stage
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_INCR = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic       sample_bit;
        logic [5:0] bin_index;
    } t_brh_in;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [5:0]  longest_run;
        logic [5:0]  open_run;
    } t_brh_out;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] longest_run;
        logic [5:0] open_run;
    } t_brh_upd;

endpackage

`default_nettype wire

// ----- hdl/brh_hist_mem.sv -----
`default_nettype none

module brh_hist_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read-first: a read and a write to one entry in one cycle return the old value
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/brh_run_track.sv -----
`default_nettype none

module brh_run_track #(
    parameter int BINS = 64,
    parameter int AW   = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire brh_pkg::t_brh_in i_item,
    output brh_pkg::t_brh_upd     o_upd,
    output logic [AW-1:0]         o_addr
);

    import brh_pkg::*;

    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_longest, n_longest;
    logic          r_prev, n_prev;
    logic          r_started, n_started;
    logic [1:0]    op;
    logic [AW-1:0] addr;

    always_comb begin
        n_cnt     = r_cnt;
        n_longest = r_longest;
        n_prev    = r_prev;
        n_started = r_started;
        op        = OP_NONE;
        addr      = AW'(i_item.bin_index);
        if (i_item.cmd == CMD_READ) begin
            if (32'(i_item.bin_index) < 32'(BINS)) begin
                op = OP_READ;
            end
        end else begin
            n_started = 1'b1;
            n_prev    = i_item.sample_bit;
            if (!r_started) begin
                n_cnt = AW'(1);
            end else if (i_item.sample_bit == r_prev) begin
                // run length saturates at the last bin
                if (r_cnt != AW'(BINS - 1)) begin
                    n_cnt = r_cnt + AW'(1);
                end
            end else begin
                op   = OP_INCR;
                addr = r_cnt;
                if (r_cnt > r_longest) begin
                    n_longest = r_cnt;
                end
                n_cnt = AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_longest <= '0;
            r_prev    <= 1'b0;
            r_started <= 1'b0;
        end else if (i_take) begin
            r_cnt     <= n_cnt;
            r_longest <= n_longest;
            r_prev    <= n_prev;
            r_started <= n_started;
        end
    end

    always_comb begin
        o_upd.op          = op;
        o_upd.longest_run = (32'(n_longest) > 32'd63) ? 6'd63 : 6'(n_longest);
        o_upd.open_run    = (32'(n_cnt) > 32'd63) ? 6'd63 : 6'(n_cnt);
    end

    assign o_addr = addr;

endmodule

`default_nettype wire

// ----- hdl/bit_run_length_histogram.sv -----
// Run-length histogram of a bit stream. Each item is either a sample bit (cmd 0) or
// a read of one histogram bin (cmd 1), and each gives exactly one result carrying
// the bin count (zero for samples), the longest finished run and the open run
// length. The bins live in a single-port-read, single-port-write memory that is
// updated by read-modify-write; back-to-back updates of one bin are forwarded, so
// one item is taken every cycle while results are drained. An accepted item passes
// through the memory stage and the output register before its result is offered.
// A result held by the receiver stalls the input once the memory stage is full.
// After reset a clearing pass zeroes the memory, one bin a cycle, and no item is
// accepted until it is done.
`default_nettype none
`include "bit_run_length_histogram_assert.svh"

module bit_run_length_histogram #(
    parameter int BINS        = brh_pkg::BRH_BINS,
    parameter int COUNT_WIDTH = brh_pkg::BRH_COUNT_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire brh_pkg::t_brh_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output brh_pkg::t_brh_out      o_out_data
);

    import brh_pkg::*;

    localparam int AW = $clog2(BINS);

    logic                   accept;
    logic                   s1_adv;
    t_brh_upd               upd;
    logic [AW-1:0]          s0_addr;

    logic                   r_clr_busy;
    logic [AW-1:0]          r_clr_addr;

    logic                   r_s1_valid;
    logic [1:0]             r_s1_op;
    logic [AW-1:0]          r_s1_addr;
    logic [5:0]             r_s1_longest;
    logic [5:0]             r_s1_open;
    logic                   r_fwd;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic                   r_out_valid;
    t_brh_out               r_out_data;

    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] inc;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept     = i_in_valid && o_in_ready;

    brh_run_track #(
        .BINS (BINS),
        .AW   (AW)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (accept),
        .i_item  (i_in_data),
        .o_upd   (upd),
        .o_addr  (s0_addr)
    );

    // bin value seen by the item in the memory stage
    assign cur = r_fwd ? r_fwd_data : rd_data;
    assign inc = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);

    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = s1_adv && (r_s1_op == OP_INCR);
            wr_addr = r_s1_addr;
            wr_data = inc;
        end
    end

    brh_hist_mem #(
        .DEPTH (BINS),
        .WIDTH (COUNT_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (s0_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // memory stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            // the write leaving this cycle misses the read issued now
            r_fwd      <= s1_adv && (r_s1_op == OP_INCR) && (s0_addr == r_s1_addr);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= upd.op;
            r_s1_addr    <= s0_addr;
            r_s1_longest <= upd.longest_run;
            r_s1_open    <= upd.open_run;
            r_fwd_data   <= inc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data.bin_count   <= (r_s1_op == OP_READ) ? 32'(cur) : 32'd0;
            r_out_data.longest_run <= r_s1_longest;
            r_out_data.open_run    <= r_s1_open;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `BRH_ASSERT_IMP(a_no_take_clearing, i_clk, i_rst_n, r_clr_busy, !o_in_ready, "item taken during clearing pass")
    `BRH_ASSERT_IMP(a_clear_done_empty, i_clk, i_rst_n, $fell(r_clr_busy), !r_s1_valid && !r_out_valid, "items in flight during clearing pass")
    `BRH_ASSERT_IMP(a_no_bin_zero_incr, i_clk, i_rst_n, r_s1_valid && (r_s1_op == OP_INCR), r_s1_addr != '0, "increment of bin zero")
    `BRH_ASSERT_IMP(a_fwd_follows_write, i_clk, i_rst_n, r_fwd && r_s1_valid && $past(accept), $past(wr_en) && ($past(wr_addr) == r_s1_addr), "forward without matching write")

endmodule

`default_nettype wire
